[rtl/core/sfr_pkg.sv]
// Shared constants and types for the stream find-and-replace block.
`timescale 1ns / 1ps
package sfr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int ENTRY_BYTES     = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                    : MAX_REPLACEMENT;
   localparam int LEN_W           = 4;
   localparam int WIN_IDX_W       = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 64;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = 1;
   localparam int QUEUE_CNT_W     = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ENTRY_BYTES-1:0][7:0] bytes;
      logic [LEN_W-1:0]            count;
      logic                        fin;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

[rtl/core/stream_find_replace.sv]
// Top level of the streaming find-and-replace block.
`timescale 1ns / 1ps
// Replaces every non-overlapping occurrence of a 1 to 8 byte pattern in a byte stream with
// a 0 to 8 byte replacement. One input byte is accepted per clock cycle; the front end
// compares its window with the pattern in parallel and queues the bytes the transaction
// releases (none up to eight) in a two-entry queue. The output register delivers one
// result per cycle while rsp_stall is low, so a transaction that releases several results
// holds the output side until all are delivered, and the input stalls only once the queue
// fills. A final byte flushes the window and the last result of the stream carries
// stream_end; if nothing is left to emit, a single end marker with byte_valid low is
// returned. Write the configuration registers only while no transaction is in flight.
module stream_find_replace
   import sfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_final_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_run_last,
   output logic                   rsp_stream_end
);

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head;
   logic             push;
   logic             pop;

   sfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_final_byte (req_final_byte),
      .q_status       (q_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   sfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

[rtl/core/sfr_front.sv]
// Front end: configuration registers, match window and classification of each byte.
`timescale 1ns / 1ps
module sfr_front
   import sfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_final_byte,
   input  queue_status_type       q_status,
   output logic                   push,
   output entry_type              push_entry
);

   logic [63:0]                   pat_ff;
   logic [LEN_W-1:0]              plen_ff;
   logic [63:0]                   repl_ff;
   logic [LEN_W-1:0]              rlen_ff;
   logic [MAX_PATTERN-1:0][7:0]   win_ff;
   logic [MAX_PATTERN-1:0][7:0]   win_in;
   logic [WIN_IDX_W-1:0]          wc_ff;
   logic [WIN_IDX_W-1:0]          wc_in;

   logic [MAX_PATTERN-1:0][7:0]   seq;
   logic [MAX_PATTERN-1:0][7:0]   shifted;
   logic [LEN_W-1:0]              p_eff;
   logic [LEN_W-1:0]              r_eff;
   logic [LEN_W-1:0]              n;
   logic [LEN_W-1:0]              drop;
   logic [LEN_W-1:0]              src;
   logic                          match;
   logic                          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= LEN_W'(1);
         repl_ff <= '0;
         rlen_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:      pat_ff  <= csr_wdata;
            CSR_PATTERN_LENGTH:     plen_ff <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  repl_ff <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: rlen_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (plen_ff == '0) begin
         p_eff = LEN_W'(1);
      end else if (plen_ff > LEN_W'(MAX_PATTERN)) begin
         p_eff = LEN_W'(MAX_PATTERN);
      end else begin
         p_eff = plen_ff;
      end
      r_eff = (rlen_ff > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_ff;

      n = {1'b0, wc_ff} + LEN_W'(1);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (WIN_IDX_W'(i) < wc_ff) begin
            seq[i] = win_ff[i];
         end else if (WIN_IDX_W'(i) == wc_ff) begin
            seq[i] = req_in_byte;
         end else begin
            seq[i] = 8'h00;
         end
      end

      match = (n == p_eff);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((LEN_W'(i) < p_eff) && (seq[i] != pat_ff[8*i +: 8])) begin
            match = 1'b0;
         end
      end

      drop = n - (p_eff - LEN_W'(1));
      for (int i = 0; i < MAX_PATTERN; i++) begin
         src = LEN_W'(i) + drop;
         shifted[i] = (src < LEN_W'(MAX_PATTERN)) ? seq[src[WIN_IDX_W-1:0]] : 8'h00;
      end

      for (int i = 0; i < ENTRY_BYTES; i++) begin
         if (match) begin
            push_entry.bytes[i] = (i < MAX_REPLACEMENT) ? repl_ff[8*i +: 8] : 8'h00;
         end else begin
            push_entry.bytes[i] = (i < MAX_PATTERN) ? seq[i] : 8'h00;
         end
      end
      if (match) begin
         push_entry.count = r_eff;
      end else if (req_final_byte) begin
         push_entry.count = n;
      end else if (n < p_eff) begin
         push_entry.count = '0;
      end else begin
         push_entry.count = drop;
      end
      push_entry.fin = req_final_byte;

      win_in = win_ff;
      wc_in  = wc_ff;
      if (match || req_final_byte) begin
         wc_in = '0;
      end else if (n < p_eff) begin
         win_in = seq;
         wc_in  = n[WIN_IDX_W-1:0];
      end else begin
         win_in = shifted;
         wc_in  = WIN_IDX_W'(p_eff - LEN_W'(1));
      end
   end

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept && ((push_entry.count != '0) || push_entry.fin);

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff <= '0;
      end else if (accept) begin
         wc_ff <= wc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

[rtl/core/sfr_queue.sv]
// Short queue of classified transactions between front end and output sequencer.
`timescale 1ns / 1ps
module sfr_queue
   import sfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type q_status
);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff;
   logic [QUEUE_CNT_W-1:0] cnt_in;

   assign q_status.full      = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.not_empty = (cnt_ff != '0);
   assign head               = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/sfr_back.sv]
// Back end: walks each queued transaction and drives one result per cycle while rsp_stall is low.
`timescale 1ns / 1ps
module sfr_back
   import sfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  entry_type        head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_run_last,
   output logic             rsp_stream_end
);

   logic [WIN_IDX_W-1:0] idx_ff;
   logic                 valid_ff;
   logic [7:0]           byte_ff;
   logic                 bvalid_ff;
   logic                 last_ff;
   logic                 end_ff;
   logic [LEN_W-1:0]     total;
   logic                 is_last;
   logic                 load;

   always_comb begin
      total   = (head.count == '0) ? LEN_W'(1) : head.count;
      is_last = ({1'b0, idx_ff} == (total - LEN_W'(1)));
   end

   assign load = q_status.not_empty && (!valid_ff || !rsp_stall);
   assign pop  = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
         if (load) begin
            idx_ff <= is_last ? '0 : idx_ff + WIN_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= (head.count == '0) ? 8'h00 : head.bytes[idx_ff];
         bvalid_ff <= (head.count != '0);
         last_ff   <= is_last;
         end_ff    <= is_last && head.fin;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_stream_end = end_ff;

endmodule

[rtl/core/sfr_checker.sv]
// Port-level assertions for the stream find-and-replace block and their bind.
`timescale 1ns / 1ps
module sfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_stream_end
);

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stalled_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_run_last) && $stable(rsp_stream_end))
      else $error("stalled result changed");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end on a result that is not the last of its transaction");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'h00 && rsp_run_last
         && rsp_stream_end)
      else $error("empty end marker malformed");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_run_last   (rsp_run_last),
   .rsp_stream_end (rsp_stream_end)
);
